### src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define SLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

`define SLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`else

`define SLE_ASSERT(lbl, clk, rst_n, prop)

`define SLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/sle_pkg.sv
package sle_pkg;

  localparam int LINE_LEN = 32;
  localparam int IDX_W    = $clog2(LINE_LEN);
  localparam int FILL_W   = 6;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int STEP_W   = 3;

  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_RETYPE = 8'd18;
  localparam logic [7:0] CH_KILL   = 8'd21;
  localparam logic [7:0] CH_SP     = 8'd32;
  localparam logic [7:0] CH_X      = 8'd88;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_BS,
    OP_RETYPE,
    OP_KILL,
    OP_EOL,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEQ,
    ST_CHECK,
    ST_TAIL
  } st_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        tx_byte;
    logic              line_done;
    logic [FILL_W-1:0] line_length;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [7:0] seq_byte(op_t op, logic [STEP_W-1:0] step);
    logic [7:0] b;
    unique case (op)
      OP_BS:                b = (step == STEP_W'(1)) ? CH_SP : CH_BS;
      OP_KILL:              b = (step < STEP_W'(3)) ? CH_X :
                                (step == STEP_W'(3)) ? CH_CR : CH_LF;
      OP_EOL, OP_RETYPE:    b = (step == '0) ? CH_CR : CH_LF;
      default:              b = CH_CR;
    endcase
    return b;
  endfunction

  function automatic logic [STEP_W-1:0] seq_last(op_t op);
    logic [STEP_W-1:0] s;
    unique case (op)
      OP_BS:   s = STEP_W'(2);
      OP_KILL: s = STEP_W'(4);
      default: s = STEP_W'(1);
    endcase
    return s;
  endfunction

endpackage

### src/serial_line_editor.sv
// Line editor for a serial terminal.
// Input channel in_valid/in_ready/in_data carries one received byte (mode 0)
// or a clear command (mode 1). Output channel out_valid/out_ready/out_data
// carries one echo byte per transfer, with line_done and line_length on the
// LF that ends an end-of-line echo, and last on the final echo of an item.
// Items enter a two-entry command queue after decode; the executor owns the
// 32-byte line store (one write and one registered read port) and the fill
// count, and drives a single output register.
// An item passes the queue; its first echo then enters the output register.
// Throughput: one echo per cycle while out_ready stays high; an item gives
// up to 34 echoes, for Ctrl-R retyping a full line (CR, LF and 32 stored
// bytes, one store read per byte).
// Reset (rst_n low, synchronous) empties the queue, clears the fill count
// and the output register valid; the store needs no clearing since only
// entries below the fill count are ever read.
// With out_valid high and out_ready low the output register holds and the
// executor stalls; the queue accepts until it is full, then in_ready drops.
module serial_line_editor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sle_pkg::out_item_t out_data
);
  import sle_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  sle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  sle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### src/sle_ram.sv
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/sle_front.sv
`include "assert_macros.svh"

module sle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sle_pkg::in_item_t in_data,
  output logic              q_valid,
  output sle_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);
  import sle_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  cmd_t              cmd_in;
  logic              push;

  always_comb begin
    cmd_in.ch = in_data.rx_byte;
    if (in_data.mode) begin
      cmd_in.op = OP_CLEAR;
    end else begin
      unique case (in_data.rx_byte) inside
        CH_BS, CH_DEL: cmd_in.op = OP_BS;
        CH_RETYPE:     cmd_in.op = OP_RETYPE;
        CH_KILL:       cmd_in.op = OP_KILL;
        CH_LF, CH_CR:  cmd_in.op = OP_EOL;
        default:       cmd_in.op = OP_CHAR;
      endcase
    end
  end

  assign in_ready = (count_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !q_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  `SLE_ASSERT(a_count_range, clk, rst_n, count_r <= QCNT_W'(QDEPTH))
  `SLE_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, count_r != '0)

endmodule

### src/sle_back.sv
`include "assert_macros.svh"

module sle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sle_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sle_pkg::out_item_t out_data
);
  import sle_pkg::*;

  st_t               state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] ptr_r, ptr_nxt;
  logic [FILL_W-1:0] ptr_inc;
  logic [7:0]        pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;
  out_item_t         item;
  logic              emit;
  logic              can_emit;
  logic              go;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;

  sle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_LEN)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign can_emit = !out_valid_r || out_ready;
  assign go       = q_valid && can_emit;
  assign ptr_inc  = ptr_r + FILL_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          unique case (q_cmd.op)
            OP_BS:            state_nxt = (fill_r != '0) ? ST_SEQ : ST_IDLE;
            OP_KILL, OP_EOL:  state_nxt = ST_SEQ;
            OP_RETYPE:        state_nxt = (fill_r != '0) ? ST_CHECK : ST_TAIL;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEQ: begin
        if (can_emit && step_r == seq_last(op_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (can_emit) begin
          if (ram_rdata == '0) begin
            state_nxt = ST_IDLE;
          end else if (ptr_inc >= fill_r) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    item      = '0;
    op_nxt    = op_r;
    step_nxt  = step_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = pend_r;
    ram_we    = 1'b0;
    ram_waddr = fill_r[IDX_W-1:0];
    ram_wdata = q_cmd.ch;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          q_pop    = 1'b1;
          op_nxt   = q_cmd.op;
          step_nxt = STEP_W'(1);
          unique case (q_cmd.op)
            OP_CLEAR: begin
              fill_nxt = '0;
            end
            OP_CHAR: begin
              if (fill_r < FILL_W'(LINE_LEN)) begin
                ram_we       = 1'b1;
                fill_nxt     = fill_r + FILL_W'(1);
                emit         = 1'b1;
                item.tx_byte = q_cmd.ch;
                item.last    = 1'b1;
              end
            end
            OP_BS: begin
              if (fill_r != '0) begin
                fill_nxt     = fill_r - FILL_W'(1);
                emit         = 1'b1;
                item.tx_byte = seq_byte(OP_BS, '0);
              end
            end
            OP_KILL: begin
              fill_nxt     = '0;
              emit         = 1'b1;
              item.tx_byte = seq_byte(OP_KILL, '0);
            end
            OP_EOL: begin
              emit         = 1'b1;
              item.tx_byte = seq_byte(OP_EOL, '0);
            end
            OP_RETYPE: begin
              emit         = 1'b1;
              item.tx_byte = seq_byte(OP_RETYPE, '0);
              pend_nxt     = CH_LF;
              ptr_nxt      = '0;
              ram_re       = (fill_r != '0);
            end
            default: ;
          endcase
        end
      end
      ST_SEQ: begin
        if (can_emit) begin
          emit         = 1'b1;
          item.tx_byte = seq_byte(op_r, step_r);
          item.last    = (step_r == seq_last(op_r));
          if (op_r == OP_EOL && item.last) begin
            item.line_done   = 1'b1;
            item.line_length = fill_r;
          end
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_CHECK: begin
        if (can_emit) begin
          emit         = 1'b1;
          item.tx_byte = pend_r;
          if (ram_rdata == '0) begin
            item.last = 1'b1;
          end else begin
            pend_nxt  = ram_rdata;
            ptr_nxt   = ptr_inc;
            ram_re    = (ptr_inc < fill_r);
            ram_raddr = ptr_inc[IDX_W-1:0];
          end
        end
      end
      ST_TAIL: begin
        if (can_emit) begin
          emit         = 1'b1;
          item.tx_byte = pend_r;
          item.last    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    step_r <= step_nxt;
    ptr_r  <= ptr_nxt;
    pend_r <= pend_nxt;
    if (emit) begin
      out_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SLE_ASSERT(a_fill_range, clk, rst_n, fill_r <= FILL_W'(LINE_LEN))
  `SLE_ASSERT_IMPL(a_read_in_line, clk, rst_n, state_r == ST_CHECK, ptr_r < fill_r)
  `SLE_ASSERT_IMPL(a_done_is_last, clk, rst_n, out_valid_r && out_r.line_done, out_r.last)
  `SLE_ASSERT_IMPL(a_len_only_done, clk, rst_n, out_valid_r && !out_r.line_done,
                   out_r.line_length == '0)

endmodule

### verif/tb_serial_line_editor.sv
`timescale 1ns / 1ps

module tb_serial_line_editor;
  import sle_pkg::*;

  localparam int TARGET_ITEMS = 430;

  class line_scoreboard;
    logic [7:0]        line_mem [LINE_LEN];
    logic [FILL_W-1:0] fill;
    out_item_t         echo_q[$];
    int                errors;
    int                checked;
    int                transfers;
    int                effective;
    int                lines_done;
    int                drops;
    int                longest_burst;

    function new();
      clear_line();
      errors        = 0;
      checked       = 0;
      transfers     = 0;
      effective     = 0;
      lines_done    = 0;
      drops         = 0;
      longest_burst = 0;
    endfunction

    function void clear_line();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      fill = '0;
    endfunction

    function op_t classify(in_item_t it);
      if (it.mode) return OP_CLEAR;
      case (it.rx_byte)
        CH_BS, CH_DEL: return OP_BS;
        CH_RETYPE:     return OP_RETYPE;
        CH_KILL:       return OP_KILL;
        CH_LF, CH_CR:  return OP_EOL;
        default:       return OP_CHAR;
      endcase
    endfunction

    function out_item_t echo(logic [7:0] b, logic done, logic [FILL_W-1:0] len);
      out_item_t e;
      e.tx_byte     = b;
      e.line_done   = done;
      e.line_length = len;
      e.last        = 1'b0;
      return e;
    endfunction

    function void note_input(in_item_t it);
      out_item_t burst[$];
      op_t       op;
      int        i;
      op = classify(it);
      transfers++;
      case (op)
        OP_CLEAR: begin
          clear_line();
        end
        OP_BS: begin
          if (fill != 0) begin
            burst.push_back(echo(CH_BS, 1'b0, '0));
            burst.push_back(echo(CH_SP, 1'b0, '0));
            burst.push_back(echo(CH_BS, 1'b0, '0));
            fill = fill - 1'b1;
            line_mem[fill] = 8'h00;
          end
        end
        OP_RETYPE: begin
          burst.push_back(echo(CH_CR, 1'b0, '0));
          burst.push_back(echo(CH_LF, 1'b0, '0));
          for (i = 0; i < fill; i++) begin
            if (line_mem[i] == 8'h00) break;
            burst.push_back(echo(line_mem[i], 1'b0, '0));
          end
        end
        OP_KILL: begin
          burst.push_back(echo(CH_X, 1'b0, '0));
          burst.push_back(echo(CH_X, 1'b0, '0));
          burst.push_back(echo(CH_X, 1'b0, '0));
          burst.push_back(echo(CH_CR, 1'b0, '0));
          burst.push_back(echo(CH_LF, 1'b0, '0));
          clear_line();
        end
        OP_EOL: begin
          burst.push_back(echo(CH_CR, 1'b0, '0));
          burst.push_back(echo(CH_LF, 1'b1, fill));
          lines_done++;
        end
        default: begin
          if (fill < LINE_LEN) begin
            line_mem[fill] = it.rx_byte;
            fill = fill + 1'b1;
            burst.push_back(echo(it.rx_byte, 1'b0, '0));
          end else begin
            drops++;
          end
        end
      endcase
      if (burst.size() > 0) begin
        burst[burst.size() - 1].last = 1'b1;
        if (burst.size() > longest_burst) longest_burst = burst.size();
        foreach (burst[j]) echo_q.push_back(burst[j]);
        effective++;
      end else if (op == OP_CLEAR) begin
        effective++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (echo_q.size() == 0) begin
        report($sformatf("echo 0x%02h with nothing expected", got.tx_byte));
        return;
      end
      want = echo_q.pop_front();
      checked++;
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("echo %0d: tx_byte 0x%02h, want 0x%02h",
                         checked, got.tx_byte, want.tx_byte));
      if (got.line_done !== want.line_done)
        report($sformatf("echo %0d: line_done %b, want %b",
                         checked, got.line_done, want.line_done));
      if (got.line_length !== want.line_length)
        report($sformatf("echo %0d: line_length %0d, want %0d",
                         checked, got.line_length, want.line_length));
      if (got.last !== want.last)
        report($sformatf("echo %0d: last %b, want %b", checked, got.last, want.last));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int snd_idle = 16;
  int rcv_idle = 68;

  line_scoreboard sb = new();

  serial_line_editor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  task automatic send_item(logic m, logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.mode    <= m;
    in_data.rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 85) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(255));
  endfunction

  task automatic type_line();
    int n;
    int k;
    int r;
    n = ($urandom_range(99) < 15) ? $urandom_range(28, 40) : $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 8) send_item(1'b0, $urandom_range(1) ? CH_BS : CH_DEL);
      else if (r < 11) send_item(1'b0, CH_RETYPE);
      else send_item(1'b0, rand_char());
    end
    r = $urandom_range(99);
    if (r < 40) begin
      send_item(1'b0, CH_CR);
    end else if (r < 75) begin
      send_item(1'b0, CH_LF);
    end else if (r < 88) begin
      send_item(1'b0, CH_RETYPE);
      send_item(1'b0, CH_CR);
    end else begin
      send_item(1'b0, CH_KILL);
    end
  endtask

  initial begin
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(1'b0, CH_BS);
    send_item(1'b0, CH_DEL);
    send_item(1'b0, CH_RETYPE);
    send_item(1'b0, CH_CR);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h41);
    send_item(1'b0, CH_RETYPE);
    send_item(1'b0, CH_BS);
    send_item(1'b0, CH_DEL);
    send_item(1'b0, CH_BS);
    send_item(1'b0, 8'h68);
    send_item(1'b0, 8'h69);
    send_item(1'b0, CH_RETYPE);
    send_item(1'b0, CH_LF);
    send_item(1'b0, CH_KILL);
    send_item(1'b0, 8'h7A);
    send_item(1'b1, 8'hA5);
    send_item(1'b1, 8'h00);
    send_item(1'b0, CH_KILL);
    send_item(1'b0, 8'h7E);
    send_item(1'b0, 8'h80);
    send_item(1'b0, CH_CR);

    while (sb.effective < TARGET_ITEMS) begin
      if (sb.effective < TARGET_ITEMS / 3) begin
        snd_idle = 16;
        rcv_idle = 68;
      end else if (sb.effective < 2 * TARGET_ITEMS / 3) begin
        snd_idle = 68;
        rcv_idle = 16;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      r = $urandom_range(99);
      if (r < 72) begin
        type_line();
      end else if (r < 86) begin
        repeat ($urandom_range(1, 5))
          send_item($urandom_range(9) == 0, 8'($urandom_range(255)));
      end else if (r < 93) begin
        send_item(1'b1, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'b0, $urandom_range(1) ? CH_BS : CH_DEL);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (sb.echo_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.echo_q.size() != 0)
      sb.report($sformatf("%0d echoes never seen", sb.echo_q.size()));

    $display("covered %0d input transfers and %0d checked echo bytes",
             sb.transfers, sb.checked);
    $display("lines completed %0d, bytes dropped on a full line %0d, longest burst %0d",
             sb.lines_done, sb.drops, sb.longest_burst);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d echoes outstanding", sb.echo_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/sle_pkg.sv
src/sle_ram.sv
src/sle_front.sv
src/sle_back.sv
src/serial_line_editor.sv
verif/tb_serial_line_editor.sv
